// ===== sv/tdf_pkg.sv =====
`default_nettype none

package tdf_pkg;

    localparam int DEF_VALUE_BITS  = 31;
    localparam int MAX_RESULTS     = 30;
    localparam int CNT_BITS        = $clog2(MAX_RESULTS);
    localparam int FIRST_DIVISOR   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/tdf_divider.sv =====
`default_nettype none

module tdf_divider
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [DIV_BITS-1:0]   divisor,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic                       rem_zero
);

    localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

    logic                  run_reg,  run_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [VALUE_BITS-1:0] quo_reg,  quo_next;
    logic [DIV_BITS-1:0]   par_reg,  par_next;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS+1:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        par_reg <= par_next;
    end

    always_comb
    begin
        trial     = {par_reg, quo_reg[VALUE_BITS-1]};
        diff      = {1'b0, trial} - {2'b00, divisor};
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        par_next  = par_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = STEP_BITS'(VALUE_BITS);
            quo_next  = dividend;
            par_next  = '0;
        end
        else if (run_reg)
        begin
            if (!diff[DIV_BITS+1])
            begin
                par_next = diff[DIV_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                par_next = trial[DIV_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (par_reg == '0);

endmodule

`default_nettype wire

// ===== sv/trial_division_factorizer.sv =====
// Trial-division prime factoriser.
//
// Input: pulse start with number while busy is low; that cycle makes the
// transfer. The prime factors come out in ascending order, repeated by
// multiplicity, one per cycle in which valid is high, with last high on the
// final one. Input 0 or 1 gives one result with factor 0, is_factor 0.
// The receiver cannot stall: each result is shown for exactly one cycle.
//
// Timing: one shared restoring divider settles one quotient bit per cycle;
// each trial division goes through check, divide and update. The work on
// an item grows with trials, the count of divisions up to the square root
// of the largest prime factor left; at 31 bits the worst case is about
// 46341 trials.
// Input 0 or 1 gives its result in the cycle after the transfer.
// For input 2 or more, busy goes high after the transfer and stays high
// until the last result is shown, and one item is worked on at a time.
//
// Reset: asynchronous, active low; clears the sequencer and the result
// strobe. The block takes a new item in the first cycle after reset.
`default_nettype none

module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] number,
    output logic                       valid,
    output logic [VALUE_BITS-1:0]      factor,
    output logic                       is_factor,
    output logic                       last
);

    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = 2 * DIV_BITS;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] rem_reg,   rem_next;
    logic [DIV_BITS-1:0]   div_reg,   div_next;
    logic [SQ_BITS-1:0]    sq_reg,    sq_next;
    logic [CNT_BITS-1:0]   cnt_reg,   cnt_next;
    logic                  valid_reg, valid_next;
    logic [VALUE_BITS-1:0] factor_reg, factor_next;
    logic                  is_factor_reg, is_factor_next;
    logic                  last_reg,  last_next;

    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic                  div_rem_zero;

    tdf_divider #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (div_reg),
        .done     (div_done),
        .quotient (div_quo),
        .rem_zero (div_rem_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        sq_reg        <= sq_next;
        cnt_reg       <= cnt_next;
        factor_reg    <= factor_next;
        is_factor_reg <= is_factor_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        valid_next     = 1'b0;
        factor_next    = factor_reg;
        is_factor_next = is_factor_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next = number;
                    div_next = DIV_BITS'(FIRST_DIVISOR);
                    sq_next  = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
                    cnt_next = '0;
                    if (number < VALUE_BITS'(FIRST_DIVISOR))
                    begin
                        valid_next     = 1'b1;
                        factor_next    = '0;
                        is_factor_next = 1'b0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (cnt_reg == CNT_BITS'(MAX_RESULTS - 1)
                    || sq_reg > SQ_BITS'(rem_reg))
                begin
                    valid_next     = 1'b1;
                    factor_next    = rem_reg;
                    is_factor_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (div_rem_zero)
                    begin
                        valid_next     = 1'b1;
                        factor_next    = VALUE_BITS'(div_reg);
                        is_factor_next = 1'b1;
                        last_next      = 1'b0;
                        rem_next       = div_quo;
                        cnt_next       = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        div_next = div_reg + 1'b1;
                        sq_next  = sq_reg + SQ_BITS'({div_reg, 1'b1});
                    end
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign factor    = factor_reg;
    assign is_factor = is_factor_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== sv/tdf_checker.sv =====
`default_nettype none

module tdf_checker
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [VALUE_BITS-1:0] number,
    input  wire logic                  valid,
    input  wire logic [VALUE_BITS-1:0] factor,
    input  wire logic                  is_factor,
    input  wire logic                  last
);

    // transfer either starts work or answers a trivial input at once
    a_start_effect: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || (valid && last && !is_factor))
        else $error("transfer neither started work nor answered");

    a_no_factor: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !is_factor |-> last && (factor == '0) && !busy)
        else $error("bad no-factor result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("non-final result while idle");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && last && is_factor)
        else $error("work ended without a final factor");

    a_small_input: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (number < VALUE_BITS'(FIRST_DIVISOR)) |=> !busy)
        else $error("trivial input left the block busy");

endmodule

bind trial_division_factorizer tdf_checker #(.VALUE_BITS(VALUE_BITS)) u_tdf_checker (.*);

`default_nettype wire
